FILE: src/broadcast_ring_buffer_defines.svh
// Assertion macros used by the broadcast ring buffer checker.
`ifndef BROADCAST_RING_BUFFER_DEFINES_SVH
`define BROADCAST_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define BRB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Next-cycle implication, sampled on clk and idle during reset.
`define BRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

FILE: src/brb_pkg.sv
// Types and codes of the broadcast ring buffer.
package brb_pkg;

	localparam int DATA_W = 32;
	localparam int SLOT_W = 4;
	localparam int ID_W   = 3;
	localparam int TR_W   = 4;
	localparam int MW_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef logic [1:0] status_t;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_RETRY = 2'd1;
	localparam status_t ST_QUOTA = 2'd2;
	localparam status_t ST_BADID = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_READERS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WRITES    = 1'd1;

	localparam logic [TR_W-1:0] TOTAL_READERS_RST = 4'd1;
	localparam logic [MW_W-1:0] MAX_WRITES_RST    = 16'hFFFF;
	localparam logic [MW_W-1:0] WRITES_SAT        = 16'hFFFF;

endpackage

FILE: src/brb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/broadcast_ring_buffer.sv
// Top level of the broadcast ring buffer: control, ring RAM and result register.
//
// A ring of DEPTH 32-bit words that every configured reader must read once
// before a word retires. Each request (write or read) answers with exactly one
// result: status, read_value and slot. The block takes one request per clock
// while in_ready is high and answers through stage 1, which waits for the
// registered RAM read port, and the output register; pointers, fill count,
// seen mask and counters live in flops and are updated in the cycle of the
// input transfer, so back-to-back requests always see the effect of the one
// before. An untaken full output register stalls the input once stage 1 is full.
// Configuration writes take effect in the cycle after their transfer and must
// only be issued while no request is in flight; cfg_ready is always high.
module broadcast_ring_buffer #(
	parameter int DEPTH       = 16,
	parameter int MAX_READERS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [brb_pkg::ID_W-1:0]            reader_id,
	input  logic signed [brb_pkg::DATA_W-1:0]   data_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output brb_pkg::status_t                    status,
	output logic signed [brb_pkg::DATA_W-1:0]   read_value,
	output logic [brb_pkg::SLOT_W-1:0]          slot,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [brb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [brb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import brb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int RW = $clog2(MAX_READERS + 1);

	logic [AW-1:0]          head_q, tail_q;
	logic [FW-1:0]          fill_q;
	logic [MAX_READERS-1:0] seen_q;
	logic [RW-1:0]          rdone_q;
	logic [MW_W-1:0]        wdone_q;
	logic [TR_W-1:0]        cfg_readers_q;
	logic [MW_W-1:0]        cfg_max_writes_q;

	logic                   valid_s1;
	status_t                status_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic                   rd_s1;

	logic                   out_valid_q;
	status_t                status_q;
	logic [DATA_W-1:0]      read_value_q;
	logic [SLOT_W-1:0]      slot_q;

	logic                   accept, advance_s1;
	logic                   full, quota, id_ok, seen_hit, retire;
	logic                   write_ok, read_ok;
	logic [RW-1:0]          n_eff;
	logic [RW:0]            rdone_inc;
	logic [MAX_READERS-1:0] id_onehot;
	status_t                status_d;
	logic [SLOT_W-1:0]      slot_d;
	logic [DATA_W-1:0]      ram_rdata;
	logic [AW-1:0]          head_next, tail_next;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !(valid_s1 && out_valid_q && !out_ready);
	assign accept     = in_valid && in_ready;
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);

	// Clamp the configured reader count into 1..MAX_READERS.
	always_comb begin
		priority if (cfg_readers_q == '0) begin
			n_eff = RW'(1);
		end else if (int'(cfg_readers_q) > MAX_READERS) begin
			n_eff = RW'(MAX_READERS);
		end else begin
			n_eff = RW'(cfg_readers_q);
		end
	end

	assign full      = (fill_q == FW'(DEPTH));
	assign quota     = (wdone_q >= cfg_max_writes_q);
	assign id_ok     = (32'(reader_id) < 32'(n_eff));
	assign id_onehot = MAX_READERS'(1) << reader_id;
	assign seen_hit  = |(seen_q & id_onehot);
	assign rdone_inc = {1'b0, rdone_q} + (RW + 1)'(1);
	assign retire    = (rdone_inc >= {1'b0, n_eff});
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_next = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);

	always_comb begin
		write_ok = 1'b0;
		read_ok  = 1'b0;
		status_d = ST_DONE;
		slot_d   = '0;
		if (opcode == OP_WRITE) begin
			priority if (full) begin
				status_d = ST_RETRY;
			end else if (quota) begin
				status_d = ST_QUOTA;
			end else begin
				write_ok = 1'b1;
				slot_d   = SLOT_W'(tail_q);
			end
		end else begin
			priority if (!id_ok) begin
				status_d = ST_BADID;
			end else if (fill_q == '0 || seen_hit) begin
				status_d = ST_RETRY;
			end else begin
				read_ok = 1'b1;
				slot_d  = SLOT_W'(head_q);
			end
		end
	end

	brb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (accept && write_ok),
		.waddr(tail_q),
		.wdata(data_value),
		.re   (accept && read_ok),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// Ring pointers and per-word reader tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			seen_q  <= '0;
			rdone_q <= '0;
			wdone_q <= '0;
		end else if (accept) begin
			if (write_ok) begin
				tail_q <= tail_next;
				fill_q <= fill_q + FW'(1);
				if (wdone_q != WRITES_SAT) begin
					wdone_q <= wdone_q + MW_W'(1);
				end
			end
			if (read_ok) begin
				if (retire) begin
					head_q  <= head_next;
					seen_q  <= '0;
					rdone_q <= '0;
					fill_q  <= fill_q - FW'(1);
				end else begin
					seen_q  <= seen_q | id_onehot;
					rdone_q <= rdone_inc[RW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_readers_q    <= TOTAL_READERS_RST;
			cfg_max_writes_q <= MAX_WRITES_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOTAL_READERS: cfg_readers_q    <= cfg_data[TR_W-1:0];
				REG_MAX_WRITES:    cfg_max_writes_q <= cfg_data[MW_W-1:0];
				default:           ;
			endcase
		end
	end

	// Stage 1 waits for the RAM read; hold it while the output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			slot_s1   <= slot_d;
			rd_s1     <= read_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			status_q     <= status_s1;
			slot_q       <= slot_s1;
			read_value_q <= rd_s1 ? ram_rdata : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign slot       = slot_q;

endmodule

FILE: src/brb_checker.sv
// Port-level checker for the broadcast ring buffer, bound to the top level.
`include "broadcast_ring_buffer_defines.svh"

module brb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input brb_pkg::status_t                  status,
	input logic signed [brb_pkg::DATA_W-1:0] read_value,
	input logic [brb_pkg::SLOT_W-1:0]        slot
);

	import brb_pkg::*;

	logic [1:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Count requests transferred in but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`BRB_ASSERT_NOW(a_refused_zero, out_valid && status != ST_DONE,
		read_value == '0 && slot == '0)
	`BRB_ASSERT_NOW(a_pending_bound, 1'b1, pending_q <= 2'd2)
	`BRB_ASSERT_NOW(a_no_orphan_result, out_valid, pending_q != 2'd0)
	`BRB_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)
	`BRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(read_value) && $stable(slot))

endmodule

bind broadcast_ring_buffer brb_checker u_brb_checker (.*);
